### design/acfz_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package acfz_pkg;

  // Width of the lag field on the result channel
  localparam int unsigned LAG_WIDTH = 10;

  // Products are summed modulo 2^64
  localparam int unsigned ACC_WIDTH = 64;

  // Sequencer states
  typedef enum logic [5:0] {
    ST_LOAD       = 6'b000001,
    ST_PREP       = 6'b000010,
    ST_PREP_DRAIN = 6'b000100,
    ST_SEARCH     = 6'b001000,
    ST_DRAIN      = 6'b010000,
    ST_DONE       = 6'b100000
  } state_e;

endpackage

`default_nettype wire

### design/acfz_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Sample channel
interface acfz_in_if #(
  parameter int unsigned SAMPLE_WIDTH = 16
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

// Result channel
interface acfz_out_if ();
  logic                              valid;
  logic                              ready;
  logic [acfz_pkg::LAG_WIDTH-1:0]    first_zero_lag;
  logic                              truncated;

  modport source (output valid, output first_zero_lag, output truncated, input ready);
  modport sink   (input valid, input first_zero_lag, input truncated, output ready);
endinterface

`default_nettype wire

### design/acfz_store.sv
`timescale 1ns / 1ps
`default_nettype none

// Sample / deviation store: one write port, two registered read ports
module acfz_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 28,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

`default_nettype wire

### design/acf_first_zero_crossing_core.sv
`timescale 1ns / 1ps
`default_nettype none

// First zero crossing of the autocorrelation. Samples stream in one per cycle until
// an item with last set; the block then returns the smallest lag k in 1..N-2 at
// which sum (N*x[i]-S)*(N*x[i+k]-S) is negative, or 0 if none (or N < 3), plus a
// flag telling whether samples past MAX_LEN were dropped. After the last sample the
// block stops accepting and runs one shared multiplier: it first turns each stored
// sample into N*x-S in place, then forms the sum of products for every lag k it
// tests; the multiply-accumulate throughput of that single unit, fed by a
// two-read-port store, sets the search time. The result waits in an output
// register and loading of the next series resumes once it is written there.
module acf_first_zero_crossing_core #(
  parameter int unsigned MAX_LEN      = 1024,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  acfz_in_if.sink          in_i,
  acfz_out_if.source       out_o
);

  localparam int unsigned AW    = $clog2(MAX_LEN);
  localparam int unsigned CW    = $clog2(MAX_LEN + 1);
  localparam int unsigned SUM_W = SAMPLE_WIDTH + CW;
  localparam int unsigned DW    = SUM_W + 1;
  localparam int unsigned PW    = 2 * DW;
  localparam int unsigned AccW  = acfz_pkg::ACC_WIDTH;
  localparam int unsigned EXT_W = (PW > AccW) ? PW : AccW;

  acfz_pkg::state_e state_q, state_d;

  logic [CW-1:0]              count_q, count_d;
  logic signed [SUM_W-1:0]    sum_q, sum_d;
  logic                       ovf_q, ovf_d;
  logic [AW-1:0]              lag_q, lag_d;
  logic [AW-1:0]              pair_q, pair_d;
  logic [AW-1:0]              res_lag_q, res_lag_d;
  logic [AccW-1:0]            acc_q, acc_d;
  logic                       v1_q, v1_d;
  logic                       v2_q;
  logic [AW-1:0]              wa1_q, wa2_q;
  logic signed [PW-1:0]       mul_q;

  logic                                out_valid_q, out_valid_d;
  logic [acfz_pkg::LAG_WIDTH-1:0]      out_lag_q, out_lag_d;
  logic                                out_trunc_q, out_trunc_d;

  logic                 accept;
  logic                 full;
  logic [CW-1:0]        n_last;
  logic [DW-1:0]        sample_ext;
  logic                 prep_mode;
  logic                 acc_mode;
  logic                 prep_end;
  logic                 search_end;
  logic                 lag_end;
  logic                 pipe_empty;
  logic signed [DW-1:0] op_a, op_b;
  logic [DW-1:0]        dev;
  logic signed [EXT_W-1:0] prod_ext;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DW-1:0]     mem_wdata;
  logic [AW-1:0]     mem_raddr_b;
  logic [DW-1:0]     rd_a, rd_b;

  // Handshake and status decode
  assign accept     = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == acfz_pkg::ST_LOAD);
  assign full       = (count_q == CW'(MAX_LEN));
  assign n_last     = full ? count_q : count_q + CW'(1);
  assign sample_ext = {{(DW - SAMPLE_WIDTH){in_i.sample[SAMPLE_WIDTH-1]}}, in_i.sample};
  assign prep_mode  = (state_q == acfz_pkg::ST_PREP) || (state_q == acfz_pkg::ST_PREP_DRAIN);
  assign acc_mode   = (state_q == acfz_pkg::ST_SEARCH) || (state_q == acfz_pkg::ST_DRAIN);
  assign pipe_empty = !v1_q && !v2_q;

  assign prep_end   = (CW'(pair_q) == count_q - CW'(1));
  assign search_end = ((CW + 1)'(pair_q) + (CW + 1)'(lag_q)) == ((CW + 1)'(count_q) - (CW + 1)'(1));
  assign lag_end    = (CW'(lag_q) + CW'(2)) == count_q;

  // Shared multiplier: N*x during prep, dev[i]*dev[i+k] during search
  assign op_a     = signed'(rd_a);
  assign op_b     = prep_mode ? signed'(DW'(count_q)) : signed'(rd_b);
  assign dev      = mul_q[DW-1:0] - DW'(sum_q);
  assign prod_ext = EXT_W'(mul_q);

  always_ff @(posedge clk_i) begin
    mul_q <= op_a * op_b;
    wa1_q <= pair_q;
    wa2_q <= wa1_q;
  end

  // Store port muxing
  assign mem_raddr_b = pair_q + lag_q;

  always_comb begin
    if (state_q == acfz_pkg::ST_LOAD) begin
      mem_we    = accept && !full;
      mem_waddr = count_q[AW-1:0];
      mem_wdata = sample_ext;
    end else begin
      mem_we    = prep_mode && v2_q;
      mem_waddr = wa2_q;
      mem_wdata = dev;
    end
  end

  acfz_store #(
    .DEPTH (MAX_LEN),
    .WIDTH (DW)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (pair_q),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    sum_d       = sum_q;
    ovf_d       = ovf_q;
    lag_d       = lag_q;
    pair_d      = pair_q;
    res_lag_d   = res_lag_q;
    acc_d       = acc_q;
    v1_d        = (state_q == acfz_pkg::ST_PREP) || (state_q == acfz_pkg::ST_SEARCH);
    out_valid_d = out_valid_q;
    out_lag_d   = out_lag_q;
    out_trunc_d = out_trunc_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (acc_mode && v2_q) begin
      acc_d = acc_q + prod_ext[AccW-1:0];
    end

    unique case (state_q)
      acfz_pkg::ST_LOAD: begin
        if (accept) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_q + CW'(1);
            sum_d   = sum_q + SUM_W'(signed'(sample_ext));
          end
          if (in_i.last) begin
            if (n_last < CW'(3)) begin
              res_lag_d = '0;
              state_d   = acfz_pkg::ST_DONE;
            end else begin
              pair_d  = '0;
              state_d = acfz_pkg::ST_PREP;
            end
          end
        end
      end
      acfz_pkg::ST_PREP: begin
        pair_d = pair_q + AW'(1);
        if (prep_end) begin
          state_d = acfz_pkg::ST_PREP_DRAIN;
        end
      end
      acfz_pkg::ST_PREP_DRAIN: begin
        if (pipe_empty) begin
          lag_d   = AW'(1);
          pair_d  = '0;
          acc_d   = '0;
          state_d = acfz_pkg::ST_SEARCH;
        end
      end
      acfz_pkg::ST_SEARCH: begin
        pair_d = pair_q + AW'(1);
        if (search_end) begin
          state_d = acfz_pkg::ST_DRAIN;
        end
      end
      acfz_pkg::ST_DRAIN: begin
        if (pipe_empty) begin
          if (acc_q[AccW-1]) begin
            res_lag_d = lag_q;
            state_d   = acfz_pkg::ST_DONE;
          end else if (lag_end) begin
            res_lag_d = '0;
            state_d   = acfz_pkg::ST_DONE;
          end else begin
            lag_d   = lag_q + AW'(1);
            pair_d  = '0;
            acc_d   = '0;
            state_d = acfz_pkg::ST_SEARCH;
          end
        end
      end
      acfz_pkg::ST_DONE: begin
        // hand the result to the output register, then clear the series
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_lag_d   = acfz_pkg::LAG_WIDTH'(res_lag_q);
          out_trunc_d = ovf_q;
          count_d     = '0;
          sum_d       = '0;
          ovf_d       = 1'b0;
          state_d     = acfz_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = acfz_pkg::ST_LOAD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= acfz_pkg::ST_LOAD;
      count_q     <= '0;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      lag_q       <= '0;
      pair_q      <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      ovf_q       <= ovf_d;
      lag_q       <= lag_d;
      pair_q      <= pair_d;
      v1_q        <= v1_d;
      v2_q        <= v1_q;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    acc_q       <= acc_d;
    res_lag_q   <= res_lag_d;
    out_lag_q   <= out_lag_d;
    out_trunc_q <= out_trunc_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.first_zero_lag = out_lag_q;
  assign out_o.truncated      = out_trunc_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_LEN))
    else $error("sample count above store depth");

  a_issue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == acfz_pkg::ST_SEARCH) |->
      ((CW + 1)'(pair_q) + (CW + 1)'(lag_q)) < (CW + 1)'(count_q))
    else $error("pair read beyond the stored series");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == acfz_pkg::ST_DONE))
    else $error("result raised outside the done state");

  a_lag_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == acfz_pkg::ST_DONE) |->
      (res_lag_q == '0) || ((CW'(res_lag_q) + CW'(2)) <= count_q))
    else $error("reported lag out of range");

  a_idle_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == acfz_pkg::ST_LOAD) |-> (!v1_q && !v2_q))
    else $error("multiplier pipeline busy while loading");
`endif

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned STORE_DEPTH  = 1024;
  localparam int unsigned SMP_WIDTH    = 16;
  localparam int unsigned DRAIN_CYCLES = 64;

  typedef struct packed {
    logic [acfz_pkg::LAG_WIDTH-1:0] lag;
    logic                           truncated;
  } lag_result_t;

  // Shapes of random series content
  typedef enum int unsigned {
    PAT_NOISE,
    PAT_SMALL,
    PAT_WALK,
    PAT_FLAT,
    PAT_SWING
  } pattern_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #1 clk_i = ~clk_i;

  acfz_in_if #(.SAMPLE_WIDTH(SMP_WIDTH)) in_if ();
  acfz_out_if                            out_if ();

  acf_first_zero_crossing_core #(
    .MAX_LEN      (STORE_DEPTH),
    .SAMPLE_WIDTH (SMP_WIDTH)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Series being loaded, as the block should hold it
  logic signed [SMP_WIDTH-1:0] kept_samples[$];
  longint                      kept_total  = 0;
  bit                          dropped_any = 1'b0;

  // Results owed by the block, oldest first
  lag_result_t pending_lags[$];

  int unsigned     sender_idle_pct   = 0;
  int unsigned     sink_stall_pct    = 0;
  longint unsigned cycle_count       = 0;
  longint unsigned cycle_budget      = 0;
  int unsigned     error_count       = 0;
  int unsigned     item_count        = 0;
  int unsigned     series_count      = 0;
  int unsigned     result_count      = 0;
  int unsigned     crossing_count    = 0;
  int unsigned     truncated_count   = 0;

  // Smallest lag with a negative demeaned sum of products, 0 if none
  function automatic logic [acfz_pkg::LAG_WIDTH-1:0] find_first_negative_lag();
    longint n;
    longint s;
    longint acc;
    longint a;
    longint b;
    n = longint'(kept_samples.size());
    s = kept_total;
    if (n < 3) return '0;
    for (longint k = 1; k + 2 <= n; k++) begin
      acc = 0;
      for (longint i = 0; i + k < n; i++) begin
        a = n * longint'(kept_samples[i]) - s;
        b = n * longint'(kept_samples[i + k]) - s;
        acc += a * b;
      end
      if (acc[63]) return k[acfz_pkg::LAG_WIDTH-1:0];
    end
    return '0;
  endfunction

  // Offer one item with random idle cycles ahead of it, update the prediction once taken
  task automatic send_item(input logic signed [SMP_WIDTH-1:0] smp, input logic is_last);
    longint unsigned n;
    lag_result_t     owed;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.sample <= smp;
    in_if.last   <= is_last;
    do @(posedge clk_i); while (!in_if.ready);

    item_count++;
    cycle_budget += 32;
    if (kept_samples.size() < STORE_DEPTH) begin
      kept_samples.insert(kept_samples.size(), smp);
      kept_total += longint'(smp);
    end else begin
      dropped_any = 1'b1;
    end

    if (is_last) begin
      n = kept_samples.size();
      owed.lag       = find_first_negative_lag();
      owed.truncated = dropped_any;
      pending_lags.insert(pending_lags.size(), owed);
      // full search plus preparation, with room for the result stall
      cycle_budget += n * n / 2 + 5 * n + 64;
      series_count++;
      kept_samples.delete();
      kept_total  = 0;
      dropped_any = 1'b0;
    end
  endtask

  task automatic send_series(input int vals[$]);
    foreach (vals[i]) send_item(vals[i][SMP_WIDTH-1:0], i == vals.size() - 1);
  endtask

  // Hold off the sender until every owed result is in
  task automatic wait_results_drained();
    in_if.valid <= 1'b0;
    while (pending_lags.size() != 0) @(posedge clk_i);
  endtask

  // Strongly alternating content, so lag 1 crosses and the search stays short
  task automatic send_alternating(input int unsigned count);
    int v;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 2 == 1) v = int'($urandom_range(32767, 16384));
      else v = -int'($urandom_range(32768, 16384));
      send_item(v[SMP_WIDTH-1:0], i == count - 1);
    end
  endtask

  // One series of random length and shape; mostly short, a few long
  task automatic send_random_series();
    pattern_e    pat;
    int unsigned len;
    int unsigned roll;
    int unsigned period;
    int unsigned ofs;
    int unsigned ph;
    int unsigned tri_pos;
    int          lvl;
    int          step;
    int          amp;
    int          v;
    roll = $urandom_range(99);
    if (roll < 10) len = $urandom_range(2, 1);
    else if (roll < 75) len = $urandom_range(24, 3);
    else if (roll < 95) len = $urandom_range(80, 25);
    else len = $urandom_range(160, 81);
    pat    = pattern_e'($urandom_range(PAT_SWING));
    lvl    = int'($urandom_range(65535)) - 32768;
    step   = int'($urandom_range(4096, 1));
    amp    = int'($urandom_range(32767, 1));
    period = $urandom_range(40, 4);
    ofs    = $urandom_range(period - 1);
    for (int unsigned i = 0; i < len; i++) begin
      case (pat)
        PAT_NOISE: v = int'($urandom);
        PAT_SMALL: v = lvl + int'($urandom_range(16)) - 8;
        PAT_WALK: begin
          lvl += int'($urandom_range(2 * step)) - step;
          if (lvl > 32767) lvl = 32767;
          if (lvl < -32768) lvl = -32768;
          v = lvl;
        end
        PAT_FLAT: v = lvl;
        default: begin
          // triangle wave, crossing lag follows the period
          ph      = (i + ofs) % period;
          tri_pos = (ph < period / 2) ? ph : period - ph;
          v       = amp * (4 * int'(tri_pos) - int'(period)) / int'(period);
        end
      endcase
      send_item(v[SMP_WIDTH-1:0], i == len - 1);
    end
  endtask

  task automatic test_short_series();
    send_series('{32767});
    send_series('{-32768, 32767});
  endtask

  task automatic test_flat_series();
    send_series('{-32768, -32768, -32768, -32768});
    send_series('{0, 0, 0});
  endtask

  task automatic test_extreme_swing();
    send_series('{32767, -32768, 32767});
    send_series('{-32768, 32767, -32768, 32767, -32768});
  endtask

  task automatic test_late_crossing();
    send_series('{100, 200, 300, 200, 100, -100, -200, -300, -200, -100});
  endtask

  // Store filled exactly, last sample still kept
  task automatic test_full_store();
    sender_idle_pct = 48;
    sink_stall_pct  = 0;
    send_alternating(STORE_DEPTH);
  endtask

  // Two samples past capacity, the final one among the dropped
  task automatic test_store_overflow();
    sender_idle_pct = 0;
    sink_stall_pct  = 48;
    send_alternating(STORE_DEPTH + 2);
  endtask

  task automatic test_random_series();
    int unsigned idle_pcts[4]  = '{0, 48, 0, 28};
    int unsigned stall_pcts[4] = '{0, 0, 48, 28};
    int unsigned phase_start;
    for (int p = 0; p < 4; p++) begin
      sender_idle_pct = idle_pcts[p];
      sink_stall_pct  = stall_pcts[p];
      phase_start     = item_count;
      while (item_count - phase_start < 163) send_random_series();
      wait_results_drained();
    end
  endtask

  // Result side: random stalls, each taken result checked against the oldest owed one
  always @(posedge clk_i) begin : result_check
    lag_result_t want;
    if (rst_ni) begin
      out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
      if (out_if.valid && out_if.ready) begin
        result_count++;
        if (pending_lags.size() == 0) begin
          error_count++;
          $error("result with no series pending: first_zero_lag %0d truncated %0b",
                 out_if.first_zero_lag, out_if.truncated);
        end else begin
          want = pending_lags.pop_front();
          if (want.lag != 0) crossing_count++;
          if (want.truncated) truncated_count++;
          if (out_if.first_zero_lag !== want.lag) begin
            error_count++;
            $error("first_zero_lag: expected %0d, got %0d", want.lag, out_if.first_zero_lag);
          end
          if (out_if.truncated !== want.truncated) begin
            error_count++;
            $error("truncated: expected %0b, got %0b", want.truncated, out_if.truncated);
          end
        end
      end
    end
  end

  // Watchdog, sized from the stimulus sent so far
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > 4 * cycle_budget + 10000) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_lags.size());
      $display("acf_first_zero_crossing_core: mismatch");
      $finish;
    end
  end

  initial begin
    in_if.valid  = 1'b0;
    in_if.sample = '0;
    in_if.last   = 1'b0;
    out_if.ready = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_short_series();
    test_flat_series();
    test_extreme_swing();
    test_late_crossing();
    wait_results_drained();
    test_full_store();
    wait_results_drained();
    test_store_overflow();
    wait_results_drained();
    test_random_series();

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_lags.size() != 0) begin
      error_count++;
      $error("%0d results never arrived", pending_lags.size());
    end

    $display("%0d series from %0d samples, %0d results checked in %0d cycles",
             series_count, item_count, result_count, cycle_count);
    $display("%0d results had a crossing lag, %0d flagged dropped samples",
             crossing_count, truncated_count);
    if (error_count == 0) begin
      $display("acf_first_zero_crossing_core: match");
    end else begin
      $display("acf_first_zero_crossing_core: mismatch");
    end
    $finish;
  end

endmodule

### files.f
design/acfz_pkg.sv
design/acfz_if.sv
design/acfz_store.sv
design/acf_first_zero_crossing_core.sv
tb/sv/tb.sv
